// ===== rtl/core/tlvp_pkg.sv =====
// Shared types and constants of the typed-value record stream parser.
package tlvp_pkg;

  localparam int unsigned TypeMax     = 3;
  localparam int unsigned StoreMax    = 15;
  localparam int unsigned LowBytes    = 8;
  localparam int unsigned IntLength   = 4;
  localparam int unsigned BoolLength  = 1;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_BOOL  = 2'd2,
    KIND_TEXT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } tlvp_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  length;
    logic [63:0] payload_low;
    logic [55:0] payload_high;
    status_e     status;
    logic        stream_end;
  } tlvp_out_t;

endpackage

// ===== rtl/core/tlvp_stream_if.sv =====
// Valid/ready stream channel carrying one request of a given payload type.
interface tlvp_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/typed_value_tlv_stream_parser_unit.sv =====
// Typed-value record stream parser: one byte per request, one record per result.
// Latency: a record result appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle, sustained; the single result register is the
// only stage, and a new byte is taken whenever it is empty or being drained.
// Reset (rst_ni low, asynchronous) returns the parser to the type byte and
// empties the result register; the payload bytes hold no reset value.
module typed_value_tlv_stream_parser_unit import tlvp_pkg::*; #(
  parameter int unsigned MAX_TEXT_BYTES = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlvp_stream_if.sink   in_i,
  tlvp_stream_if.source out_o
);

  localparam int unsigned StoreDepth = (MAX_TEXT_BYTES > IntLength) ? MAX_TEXT_BYTES
                                                                     : IntLength;
  localparam int unsigned IdxW       = $clog2(StoreDepth);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic        bad_q, bad_d;
  logic        disc_q, disc_d;
  logic [7:0]  store_q [StoreDepth];
  logic [7:0]  store_w [StoreDepth];
  logic        store_we;

  tlvp_out_t   out_q, res;
  logic        out_valid_q;
  logic        res_valid;
  logic        acc;

  tlvp_in_t    din;
  logic [15:0] full_len;
  logic [15:0] seen_inc;
  logic        len_ok;
  logic [7:0]  lane [StoreMax];
  logic [63:0] pack_lo;
  logic [55:0] pack_hi;

  assign din      = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc      = in_i.valid && in_i.ready;
  assign full_len = {din.byte_in, len_q[7:0]};
  assign seen_inc = seen_q + 16'd1;
  assign store_we = !disc_q && (phase_q == PH_DATA) && (seen_q < 16'(StoreDepth));

  always_comb begin
    unique case (kind_q)
      KIND_INT, KIND_FLOAT: len_ok = (full_len == 16'(IntLength));
      KIND_BOOL:            len_ok = (full_len == 16'(BoolLength));
      KIND_TEXT:            len_ok = (full_len <= 16'(MAX_TEXT_BYTES));
      default:              len_ok = 1'b0;
    endcase
  end

  // The byte that completes a record is merged in before packing.
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      store_w[i] = store_q[i];
    end
    if (store_we) begin
      store_w[seen_q[IdxW-1:0]] = din.byte_in;
    end
  end

  for (genvar g = 0; g < StoreMax; g++) begin : g_lane
    if (g < StoreDepth) begin : g_used
      assign lane[g] = (len_q > 16'(g)) ? store_w[g] : 8'd0;
    end else begin : g_unused
      assign lane[g] = 8'd0;
    end
  end

  for (genvar g = 0; g < LowBytes; g++) begin : g_lo
    assign pack_lo[8*g +: 8] = lane[g];
  end

  for (genvar g = 0; g < StoreMax - LowBytes; g++) begin : g_hi
    assign pack_hi[8*g +: 8] = lane[LowBytes + g];
  end

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    len_d     = len_q;
    seen_d    = seen_q;
    bad_d     = bad_q;
    disc_d    = disc_q;
    res_valid = 1'b0;
    res       = '0;
    res.stream_end = din.last_byte;

    if (disc_q) begin
      if (din.last_byte) begin
        disc_d  = 1'b0;
        phase_d = PH_TYPE;
      end
    end else begin
      unique case (phase_q)
        PH_TYPE: begin
          if (din.byte_in > 8'(TypeMax) || din.last_byte) begin
            res_valid  = 1'b1;
            res.status = ST_MALFORMED;
            disc_d     = !din.last_byte;
            bad_d      = 1'b0;
          end else begin
            kind_d  = kind_e'(din.byte_in[1:0]);
            phase_d = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          if (din.last_byte) begin
            res_valid  = 1'b1;
            res.status = ST_MALFORMED;
            bad_d      = 1'b0;
            phase_d    = PH_TYPE;
          end else begin
            len_d   = {8'd0, din.byte_in};
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          if (din.last_byte && full_len != 16'd0) begin
            res_valid  = 1'b1;
            res.status = ST_MALFORMED;
            bad_d      = 1'b0;
            phase_d    = PH_TYPE;
          end else begin
            len_d  = full_len;
            seen_d = 16'd0;
            if (full_len == 16'd0) begin
              // An empty record finishes on its length byte; only empty text is good.
              res_valid = 1'b1;
              phase_d   = PH_TYPE;
              if (!len_ok) begin
                res.status = ST_MALFORMED;
                bad_d      = 1'b0;
                disc_d     = !din.last_byte;
              end else begin
                res.kind   = kind_q;
                res.status = ST_GOOD;
                bad_d      = 1'b0;
              end
            end else begin
              bad_d   = !len_ok;
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          seen_d = seen_inc;
          if (seen_inc >= len_q) begin
            res_valid = 1'b1;
            phase_d   = PH_TYPE;
            if (bad_q) begin
              res.status = ST_MALFORMED;
              bad_d      = 1'b0;
              disc_d     = !din.last_byte;
            end else begin
              res.kind   = kind_q;
              res.length = len_q[3:0];
              res.status = ST_GOOD;
              if (kind_q == KIND_BOOL) begin
                res.payload_low = {63'd0, store_w[0] != 8'd0};
              end else begin
                res.payload_low  = pack_lo;
                res.payload_high = pack_hi;
              end
            end
          end else if (din.last_byte) begin
            res_valid  = 1'b1;
            res.status = ST_TRUNCATED;
            bad_d      = 1'b0;
            phase_d    = PH_TYPE;
          end
        end
        default: phase_d = PH_TYPE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TYPE;
      kind_q      <= KIND_INT;
      len_q       <= '0;
      seen_q      <= '0;
      bad_q       <= 1'b0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (acc) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        len_q   <= len_d;
        seen_q  <= seen_d;
        bad_q   <= bad_d;
        disc_q  <= disc_d;
      end
      if (in_i.ready) begin
        out_valid_q <= acc && res_valid;
        out_q       <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && store_we) begin
      store_q[seen_q[IdxW-1:0]] <= din.byte_in;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== rtl/core/tlvp_checker.sv =====
// Port-level checks of the record parser, bound to its top level.
module tlvp_checker import tlvp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input tlvp_out_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled record holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // A new record only follows an accepted byte request.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc))
    else $error("result without a byte request");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != ST_GOOD |->
      out_data_i.kind == KIND_INT && out_data_i.length == 4'd0 &&
      out_data_i.payload_low == 64'd0 && out_data_i.payload_high == 56'd0)
    else $error("error result carries record fields");

  a_num_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_GOOD &&
    (out_data_i.kind == KIND_INT || out_data_i.kind == KIND_FLOAT) |->
      out_data_i.length == 4'd4 && out_data_i.payload_high == 56'd0)
    else $error("numeric record with wrong length");

  a_bool_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_GOOD && out_data_i.kind == KIND_BOOL |->
      out_data_i.length == 4'd1 && out_data_i.payload_low[63:1] == 63'd0)
    else $error("boolean record not a single bit");

endmodule

bind typed_value_tlv_stream_parser_unit tlvp_checker u_tlvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ===== tb/tb_typed_value_tlv_stream_parser_unit.sv =====
// Self-checking testbench of the typed-value record stream parser.
module tb_typed_value_tlv_stream_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlvp_pkg::*;

  localparam int unsigned TextLimit = 15;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ByteTarget = 1750;

  typedef enum logic [1:0] {
    AT_TYPE,
    AT_LEN_LO,
    AT_LEN_HI,
    AT_PAYLOAD
  } parse_phase_e;

  // Tracks the parse of the byte stream and holds the records still owed by the block.
  class tlv_record_tracker;
    parse_phase_e phase;
    kind_e        rec_kind;
    logic [15:0]  rec_len;
    logic [15:0]  seen;
    logic [7:0]   store [StoreMax];
    bit           len_bad;
    bit           dropping;
    tlvp_out_t    expected_records [$];
    int           error_count;

    function new();
      phase = AT_TYPE;
      rec_kind = KIND_INT;
      rec_len = '0;
      seen = '0;
      len_bad = 0;
      dropping = 0;
      error_count = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void push_error(status_e st, bit last);
      tlvp_out_t rec;
      rec = '0;
      rec.kind = KIND_INT;
      rec.status = st;
      rec.stream_end = last;
      expected_records.push_back(rec);
      phase = AT_TYPE;
      len_bad = 0;
      dropping = !last;
    endfunction

    function void close_record(bit last);
      tlvp_out_t rec;
      int unsigned n;
      int unsigned i;
      if (len_bad) begin
        push_error(ST_MALFORMED, last);
        return;
      end
      rec = '0;
      n = (rec_len > StoreMax) ? StoreMax : rec_len;
      if (rec_kind == KIND_BOOL) begin
        rec.payload_low = {63'd0, store[0] != 8'd0};
      end else begin
        for (i = 0; i < n; i++) begin
          if (i < LowBytes) rec.payload_low[8*i +: 8] = store[i];
          else rec.payload_high[8*(i-LowBytes) +: 8] = store[i];
        end
      end
      rec.kind = rec_kind;
      rec.length = rec_len[3:0];
      rec.status = ST_GOOD;
      rec.stream_end = last;
      expected_records.push_back(rec);
      phase = AT_TYPE;
    endfunction

    // Returns 0 when the byte is dropped after an error.
    function bit parse_byte(tlvp_in_t req);
      logic [7:0] b;
      bit last;
      bit ok;
      b = req.byte_in;
      last = req.last_byte;
      if (dropping) begin
        if (last) begin
          dropping = 0;
          phase = AT_TYPE;
        end
        return 0;
      end
      case (phase)
        AT_TYPE: begin
          if (b > TypeMax || last) begin
            push_error(ST_MALFORMED, last);
          end else begin
            rec_kind = kind_e'(b[1:0]);
            phase = AT_LEN_LO;
          end
        end
        AT_LEN_LO: begin
          if (last) begin
            push_error(ST_MALFORMED, last);
          end else begin
            rec_len = {8'd0, b};
            phase = AT_LEN_HI;
          end
        end
        AT_LEN_HI: begin
          // A zero-length record may finish exactly on the last byte.
          if (last && !(b == 8'd0 && rec_len == 16'd0)) begin
            push_error(ST_MALFORMED, last);
          end else begin
            rec_len[15:8] = b;
            if (rec_kind == KIND_INT || rec_kind == KIND_FLOAT) ok = (rec_len == IntLength);
            else if (rec_kind == KIND_BOOL) ok = (rec_len == BoolLength);
            else ok = (rec_len <= TextLimit);
            len_bad = !ok;
            seen = '0;
            if (rec_len == 16'd0) close_record(last);
            else phase = AT_PAYLOAD;
          end
        end
        default: begin
          if (seen < StoreMax) store[seen] = b;
          seen++;
          if (seen >= rec_len) close_record(last);
          else if (last) push_error(ST_TRUNCATED, last);
        end
      endcase
      return 1;
    endfunction

    function void compare_record(tlvp_out_t got);
      tlvp_out_t want;
      if (expected_records.size() == 0) begin
        $error("record with no byte to explain it: %h", got);
        error_count++;
        return;
      end
      want = expected_records.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        error_count++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        error_count++;
      end
      if (got.payload_low !== want.payload_low) begin
        $error("payload_low: expected %h, got %h", want.payload_low, got.payload_low);
        error_count++;
      end
      if (got.payload_high !== want.payload_high) begin
        $error("payload_high: expected %h, got %h", want.payload_high, got.payload_high);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.stream_end !== want.stream_end) begin
        $error("stream_end: expected %0d, got %0d", want.stream_end, got.stream_end);
        error_count++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tlvp_stream_if #(.data_t(tlvp_in_t))  byte_if ();
  tlvp_stream_if #(.data_t(tlvp_out_t)) record_if ();

  typed_value_tlv_stream_parser_unit #(
    .MAX_TEXT_BYTES(TextLimit)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (record_if)
  );

  tlv_record_tracker tracker = new();
  logic [7:0]        frame_bytes [$];
  int unsigned       parsed_bytes = 0;
  int unsigned       hold_left = 0;
  bit                sender_idles = 1;
  bit                recv_idles = 1;
  bit                stall_request = 0;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        if (tracker.parse_byte(byte_if.data)) parsed_bytes++;
      end
      if (record_if.valid && record_if.ready) tracker.compare_record(record_if.data);
    end
  end

  // The receiver counts its own long hold-off so that the block backs up into its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      record_if.ready = 1'b0;
      hold_left--;
    end else if (stall_request) begin
      stall_request = 0;
      hold_left = HoldOffCycles;
      record_if.ready = 1'b0;
    end else begin
      record_if.ready = !(recv_idles && $urandom_range(99) < 35);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    @(negedge clk_i);
    while (sender_idles && $urandom_range(99) < 35) begin
      byte_if.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_if.data = '{byte_in: b, last_byte: last};
    byte_if.valid = 1'b1;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Appends one record; an open-ended one declares a length of 256 or more,
  // gets at most 20 payload bytes and must then end the buffer.
  task automatic add_record(input bit proper, output bit open_ended);
    int unsigned kind;
    int unsigned len;
    int unsigned count;
    open_ended = 0;
    kind = $urandom_range(TypeMax);
    case (kind_e'(kind))
      KIND_INT, KIND_FLOAT: len = IntLength;
      KIND_BOOL:            len = BoolLength;
      default:              len = $urandom_range(TextLimit);
    endcase
    if (!proper) begin
      case ($urandom_range(3))
        0: len = $urandom_range(StoreMax);
        1: len = TextLimit + 1 + $urandom_range(8);
        2: len = 0;
        default: begin
          if ($urandom_range(7) == 0) begin
            len = 256 + $urandom_range(40);
          end else begin
            len = $urandom_range(256, 65535);
            open_ended = 1;
          end
        end
      endcase
    end
    frame_bytes.push_back(kind[7:0]);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    count = open_ended ? $urandom_range(20) : len;
    repeat (count) begin
      if (kind == KIND_BOOL && $urandom_range(1) == 0) frame_bytes.push_back(8'h00);
      else frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic make_frame();
    int unsigned n;
    int unsigned keep;
    bit open_ended;
    frame_bytes.delete();
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) frame_bytes.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      open_ended = 0;
      while (n > 0 && !open_ended) begin
        add_record($urandom_range(99) >= 15, open_ended);
        n--;
      end
      // Cutting the buffer short lands its end in a header or a payload.
      if ($urandom_range(99) < 12) begin
        keep = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data = '0;
    record_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Integer with all payload bits set, then float, in one buffer.
    frame_bytes = '{8'h00, 8'h04, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h80, 8'h3F};
    send_frame();
    // Boolean false then boolean true.
    frame_bytes = '{8'h02, 8'h01, 8'h00, 8'h00, 8'h02, 8'h01, 8'h00, 8'h5A};
    send_frame();
    // Empty text finishing exactly on the last byte.
    frame_bytes = '{8'h03, 8'h00, 8'h00};
    send_frame();
    // Bad type in mid-buffer, the rest is dropped; then a bad type on the last byte.
    frame_bytes = '{8'hFF, 8'h12, 8'h00};
    send_frame();
    frame_bytes = '{8'h04};
    send_frame();
    // Buffer ends inside the length.
    frame_bytes = '{8'h02, 8'h01};
    send_frame();
    // Text payload cut short by the buffer end.
    frame_bytes = '{8'h03, 8'h05, 8'h00, 8'hAA};
    send_frame();
    // Integer with a wrong length, reported once its payload has passed.
    frame_bytes = '{8'h00, 8'h03, 8'h00, 8'h11, 8'h22, 8'h33, 8'h02, 8'h00};
    send_frame();

    stall_request = 1;
    while (parsed_bytes < ByteTarget) begin
      // A long stretch in the middle runs with both sides at full rate.
      sender_idles = !(parsed_bytes > 600 && parsed_bytes < 1000);
      recv_idles = sender_idles;
      make_frame();
      send_frame();
    end

    @(negedge clk_i);
    byte_if.valid = 1'b0;
    sender_idles = 0;
    recv_idles = 0;
    while (tracker.expected_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
